[design/ble_pkg.sv]
// ----------------------------------------------------------------------------
// ble_pkg
// Shared types and defaults for the bounded list engine: opcodes, status
// codes, sequencer states and the result flag group.
// ----------------------------------------------------------------------------
package ble_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int WIDTH_DEF = 32;

   typedef enum logic [2:0] {
      OP_APPEND  = 3'd0,
      OP_PREPEND = 3'd1,
      OP_FIND    = 3'd2,
      OP_REMOVE  = 3'd3,
      OP_POP     = 3'd4,
      OP_FRONT   = 3'd5,
      OP_NEXT    = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_MISS = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FINISH
   } state_type;

   typedef struct packed {
      status_type status;
      logic       found;
      logic       value_valid;
   } res_flags_type;

endpackage

[design/ble_mem.sv]
// ----------------------------------------------------------------------------
// ble_mem
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ble_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/ble_ctrl.sv]
// ----------------------------------------------------------------------------
// ble_ctrl
// Sequencer for the list operations. Walks the entry store one read a cycle,
// with one shared comparator acting on the returned word.
// ----------------------------------------------------------------------------
module ble_ctrl #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [2:0]                   req_opcode,
   input  logic [WIDTH-1:0]             req_operand,
   output logic                         req_ready,
   output logic                         done,
   input  logic                         done_ack,
   output ble_pkg::res_flags_type       res_flags,
   output logic [WIDTH-1:0]             res_value,
   output logic [$clog2(DEPTH+1)-1:0]   res_count,
   output logic                         mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]     mem_wr_addr,
   output logic [WIDTH-1:0]             mem_wr_data,
   output logic                         mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]     mem_rd_addr,
   input  logic [WIDTH-1:0]             mem_rd_data
);
   import ble_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam logic [CNT_W-1:0] NONE_POS = CNT_W'(DEPTH);

   state_type        state_ff, state_in;
   op_type           op_ff, op_in, req_op;
   logic [WIDTH-1:0] operand_ff, operand_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cursor_ff, cursor_in;
   logic [AW-1:0]    rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] rd_left_ff, rd_left_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0] wr_idx_ff, wr_idx_in;
   logic             found_ff, found_in;
   status_type       status_ff, status_in;
   logic [WIDTH-1:0] value_ff, value_in;
   logic             vvalid_ff, vvalid_in;

   logic             accept;
   logic             full;
   logic             empty;
   logic             cursor_ok;
   logic             walk_start;
   logic             walk_end;
   logic             match;
   logic [CNT_W-1:0] cnt_dec;
   logic [CNT_W-1:0] cursor_inc;

   assign req_op     = op_type'(req_opcode);
   assign accept     = req_valid && (state_ff == S_IDLE);
   assign full       = (count_ff == NONE_POS);
   assign empty      = (count_ff == '0);
   assign cursor_ok  = (cursor_ff < count_ff);
   assign cnt_dec    = count_ff - CNT_W'(1);
   assign cursor_inc = cursor_ff + CNT_W'(1);
   assign walk_end   = !pend_ff && (rd_left_ff == '0);
   // the shared comparator
   assign match      = (mem_rd_data == operand_ff);

   always_comb begin
      unique case (req_op)
         OP_PREPEND:         walk_start = !full;
         OP_FIND, OP_REMOVE: walk_start = 1'b1;
         OP_POP, OP_FRONT:   walk_start = !empty;
         OP_NEXT:            walk_start = cursor_ok;
         default:            walk_start = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = walk_start ? S_WALK : S_FINISH;
            end
         end
         S_WALK: begin
            if (walk_end) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (done_ack) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in       = op_ff;
      operand_in  = operand_ff;
      count_in    = count_ff;
      cursor_in   = cursor_ff;
      rd_idx_in   = rd_idx_ff;
      rd_left_in  = rd_left_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      wr_idx_in   = wr_idx_ff;
      found_in    = found_ff;
      status_in   = status_ff;
      value_in    = value_ff;
      vvalid_in   = vvalid_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = rd_idx_ff;
      req_ready   = (state_ff == S_IDLE);
      done        = (state_ff == S_FINISH);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in      = req_op;
               operand_in = req_operand;
               found_in   = 1'b0;
               status_in  = ST_OK;
               value_in   = '0;
               vvalid_in  = 1'b0;
               wr_idx_in  = '0;
               rd_idx_in  = '0;
               rd_left_in = '0;
               unique case (req_op)
                  OP_APPEND: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = count_ff[AW-1:0];
                        mem_wr_data = req_operand;
                        count_in    = count_ff + CNT_W'(1);
                        cursor_in   = NONE_POS;
                     end
                  end
                  OP_PREPEND: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        rd_idx_in  = cnt_dec[AW-1:0];
                        rd_left_in = count_ff;
                     end
                  end
                  OP_FIND, OP_REMOVE: begin
                     rd_left_in = count_ff;
                  end
                  OP_POP: begin
                     if (empty) begin
                        status_in = ST_MISS;
                     end else begin
                        rd_idx_in  = AW'(1);
                        rd_left_in = cnt_dec;
                     end
                  end
                  OP_FRONT: begin
                     if (empty) begin
                        status_in = ST_MISS;
                     end else begin
                        rd_left_in = CNT_W'(1);
                     end
                  end
                  OP_NEXT: begin
                     if (cursor_ok) begin
                        rd_idx_in  = cursor_ff[AW-1:0];
                        rd_left_in = CNT_W'(1);
                     end else begin
                        status_in = ST_MISS;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_WALK: begin
            // issue the next read
            if (rd_left_ff != '0) begin
               mem_rd_en   = 1'b1;
               rd_left_in  = rd_left_ff - CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff;
               rd_idx_in   = (op_ff == OP_PREPEND) ? rd_idx_ff - AW'(1)
                                                   : rd_idx_ff + AW'(1);
            end
            // act on the word read last cycle
            if (pend_ff) begin
               unique case (op_ff)
                  OP_PREPEND: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = pend_idx_ff + AW'(1);
                     mem_wr_data = mem_rd_data;
                  end
                  OP_FIND: begin
                     if (match) begin
                        found_in = 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (match) begin
                        found_in = 1'b1;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = wr_idx_ff[AW-1:0];
                        mem_wr_data = mem_rd_data;
                        wr_idx_in   = wr_idx_ff + CNT_W'(1);
                     end
                  end
                  OP_POP: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = pend_idx_ff - AW'(1);
                     mem_wr_data = mem_rd_data;
                  end
                  OP_FRONT, OP_NEXT: begin
                     value_in  = mem_rd_data;
                     vvalid_in = 1'b1;
                  end
                  default: ;
               endcase
            end
            // closing step once all reads are back
            if (walk_end) begin
               unique case (op_ff)
                  OP_PREPEND: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = '0;
                     mem_wr_data = operand_ff;
                     count_in    = count_ff + CNT_W'(1);
                     cursor_in   = NONE_POS;
                  end
                  OP_FIND: begin
                     status_in = found_ff ? ST_OK : ST_MISS;
                  end
                  OP_REMOVE: begin
                     if (found_ff) begin
                        count_in  = wr_idx_ff;
                        cursor_in = NONE_POS;
                        status_in = ST_OK;
                     end else begin
                        status_in = ST_MISS;
                     end
                  end
                  OP_POP: begin
                     count_in  = cnt_dec;
                     cursor_in = NONE_POS;
                  end
                  OP_FRONT: begin
                     cursor_in = (count_ff > CNT_W'(1)) ? CNT_W'(1) : NONE_POS;
                  end
                  OP_NEXT: begin
                     cursor_in = (cursor_inc < count_ff) ? cursor_inc : NONE_POS;
                  end
                  default: ;
               endcase
            end
         end

         S_FINISH: ;

         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         cursor_ff <= NONE_POS;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      operand_ff  <= operand_in;
      rd_idx_ff   <= rd_idx_in;
      rd_left_ff  <= rd_left_in;
      pend_idx_ff <= pend_idx_in;
      wr_idx_ff   <= wr_idx_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      value_ff    <= value_in;
      vvalid_ff   <= vvalid_in;
   end

   assign res_flags.status      = status_ff;
   assign res_flags.found       = found_ff;
   assign res_flags.value_valid = vvalid_ff;
   assign res_value             = value_ff;
   assign res_count             = count_ff;

endmodule

[design/bounded_list_engine_top.sv]
// ----------------------------------------------------------------------------
// bounded_list_engine_top
// Ordered list store of up to DEPTH words with append, prepend, find,
// remove-all, pop, front and next operations; one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_opcode/req_operand come in on a valid/ready channel; each transfer
//   yields exactly one transfer on the rsp_ channel (status, found, value,
//   value_valid, count after the operation).
//   One request is worked on at a time; req_ready is low from the accepting
//   edge until the result moves into the output register.
//   Append, full/empty rejects and unused opcodes go straight to the finish
//   state; front and next read one entry; prepend, find, remove and pop walk
//   up to DEPTH stored entries before their result is ready.
//   The walk is bound by the store's single read port, one entry per cycle,
//   each returned word going through the one comparator, written back or captured.
//   A result waiting in the output register does not stop the next request
//   from being accepted; the sequencer holds its finished result until the
//   output register frees up, so a stalled receiver only delays completion.
//   Reset empties the list and clears the cursor at once; store contents
//   are left as they are and never read before being written.
// ----------------------------------------------------------------------------
module bounded_list_engine_top #(
   parameter int DEPTH = ble_pkg::DEPTH_DEF,
   parameter int WIDTH = ble_pkg::WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [2:0]                 req_opcode,
   input  logic [WIDTH-1:0]           req_operand,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_found,
   output logic [WIDTH-1:0]           rsp_value,
   output logic                       rsp_value_valid,
   output logic [$clog2(DEPTH+1)-1:0] rsp_count
);
   import ble_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic             done;
   logic             load;
   res_flags_type    res_flags;
   logic [WIDTH-1:0] res_value;
   logic [CNT_W-1:0] res_count;

   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   logic [WIDTH-1:0] mem_wr_data;
   logic             mem_rd_en;
   logic [AW-1:0]    mem_rd_addr;
   logic [WIDTH-1:0] mem_rd_data;

   logic             rsp_valid_ff, rsp_valid_in;
   res_flags_type    rsp_flags_ff;
   logic [WIDTH-1:0] rsp_value_ff;
   logic [CNT_W-1:0] rsp_count_ff;

   ble_ctrl #(
      .DEPTH(DEPTH),
      .WIDTH(WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_operand(req_operand),
      .req_ready  (req_ready),
      .done       (done),
      .done_ack   (load),
      .res_flags  (res_flags),
      .res_value  (res_value),
      .res_count  (res_count),
      .mem_wr_en  (mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data),
      .mem_rd_en  (mem_rd_en),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data)
   );

   ble_mem #(
      .DEPTH(DEPTH),
      .WIDTH(WIDTH)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   // output register takes a result when empty or being drained
   assign load         = done && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_flags_ff <= res_flags;
         rsp_value_ff <= res_value;
         rsp_count_ff <= res_count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_flags_ff.status;
   assign rsp_found       = rsp_flags_ff.found;
   assign rsp_value       = rsp_value_ff;
   assign rsp_value_valid = rsp_flags_ff.value_valid;
   assign rsp_count       = rsp_count_ff;

endmodule

[design/ble_checker.sv]
// ----------------------------------------------------------------------------
// ble_checker
// Port-level checks for the bounded list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ble_checker #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [1:0]                 rsp_status,
   input logic                       rsp_found,
   input logic [WIDTH-1:0]           rsp_value,
   input logic                       rsp_value_valid,
   input logic [$clog2(DEPTH+1)-1:0] rsp_count
);
   import ble_pkg::*;

   localparam int CNT_W = $clog2(DEPTH+1);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_value) && $stable(rsp_count))
      else $error("result changed while stalled");

   // one request at a time
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in progress");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_value_valid |-> rsp_value == '0)
      else $error("value not zero without value_valid");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_count == CNT_W'(DEPTH))
      else $error("store full reported below depth");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= CNT_W'(DEPTH) && !(rsp_found && rsp_value_valid))
      else $error("count out of range or inconsistent flags");

endmodule

bind bounded_list_engine_top ble_checker #(
   .DEPTH(DEPTH),
   .WIDTH(WIDTH)
) u_ble_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_found      (rsp_found),
   .rsp_value      (rsp_value),
   .rsp_value_valid(rsp_value_valid),
   .rsp_count      (rsp_count)
);
